// ===== rtl/core/mbc1_pkg.sv =====
// Package for the MBC1 bank controller: register indexes, address regions and sizes.
package mbc1_pkg;

	// Defaults of the top-level parameters
	localparam int RAM_BYTES_DEF     = 32768;
	localparam int MAX_ROM_BANKS_DEF = 128;

	// Configuration register indexes
	localparam logic [1:0] CFG_ROM_BANK_COUNT = 2'd0;
	localparam logic [1:0] CFG_RAM_SIZE_CODE  = 2'd1;

	// Bus address regions, bus_address[15:13]
	localparam logic [2:0] REGION_RAM_ENABLE = 3'd0;
	localparam logic [2:0] REGION_ROM_BANK   = 3'd1;
	localparam logic [2:0] REGION_UPPER_BITS = 3'd2;
	localparam logic [2:0] REGION_MODE       = 3'd3;
	localparam logic [2:0] REGION_CART_RAM   = 3'd5;

	// Cartridge RAM size codes
	localparam logic [1:0] RAM_SIZE_NONE = 2'd0;
	localparam logic [1:0] RAM_SIZE_2K   = 2'd1;
	localparam logic [1:0] RAM_SIZE_8K   = 2'd2;
	localparam logic [1:0] RAM_SIZE_32K  = 2'd3;

	// Data patterns
	localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

	// Offset width of the largest RAM (32KB)
	localparam int RAM_OFF_W = 15;

	// Offset mask for a RAM size code
	function automatic logic [RAM_OFF_W-1:0] ram_off_mask(input logic [1:0] code);
		logic [RAM_OFF_W-1:0] m;
		begin
			unique case (code)
				RAM_SIZE_2K:  m = 15'h07FF;
				RAM_SIZE_8K:  m = 15'h1FFF;
				RAM_SIZE_32K: m = 15'h7FFF;
				default:      m = 15'h0000;
			endcase
			return m;
		end
	endfunction

endpackage

// ===== rtl/core/mbc1_bank_controller_core.sv =====
// Top level of the MBC1 bank controller: bank registers, cartridge RAM and result stage.

// One bus access is taken per cycle and its result is delivered in the next cycle from a
// single output register stage; a new access is taken in the same cycle its predecessor's
// result leaves, so throughput is one access per clock while the output side keeps up.
// The result is registered to match the synchronous read port of the cartridge RAM,
// which is read or written at the accepting edge. Bank and mode registers change at that
// same edge, so the next access already sees them. Configuration writes are always taken
// (cfg_ready is tied high); RAM contents are undefined after reset until written.
module mbc1_bank_controller_core
	import mbc1_pkg::*;
#(
	parameter int RAM_BYTES     = RAM_BYTES_DEF,
	parameter int MAX_ROM_BANKS = MAX_ROM_BANKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	// bus access channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [15:0] bus_address,
	input  logic [7:0]  write_byte,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  read_byte,
	output logic        rom_hit,
	output logic [20:0] rom_address,
	output logic        save_request
);

	localparam int RAM_AW = $clog2(RAM_BYTES);
	localparam logic [6:0] MAX_BANK_MASK = 7'(MAX_ROM_BANKS - 1);

	// Configuration and bank registers
	logic [7:0] rom_bank_count_q;
	logic [1:0] ram_size_code_q;
	logic       ram_on_q;
	logic [6:0] rom_bank_q;
	logic [1:0] ram_bank_q;
	logic       bank_mode_q;

	// Cartridge RAM
	logic [7:0] cart_ram [RAM_BYTES];
	logic [7:0] ram_rd_data_q;

	// Result stage
	logic        valid_s1;
	logic        sel_ram_s1;
	logic        rom_hit_s1;
	logic [20:0] rom_address_s1;
	logic        save_s1;

	// Decode of the incoming transaction
	logic                 accept;
	logic [2:0]           region;
	logic                 ram_present;
	logic [6:0]           bank_mask;
	logic [4:0]           low_bits;
	logic                 new_ram_on;
	logic [RAM_OFF_W-1:0] ram_off;
	logic [RAM_AW-1:0]    ram_idx;
	logic                 ram_access;
	logic                 ram_we;
	logic                 ram_re;
	logic [6:0]           rom_bank_sel;

	assign cfg_ready = 1'b1;
	assign in_ready  = !valid_s1 || out_ready;
	assign accept    = in_valid && in_ready;

	always_comb begin
		region       = bus_address[15:13];
		ram_present  = (ram_size_code_q != RAM_SIZE_NONE);
		bank_mask    = 7'(rom_bank_count_q - 8'd1) & MAX_BANK_MASK;
		low_bits     = (write_byte[4:0] == 5'd0) ? 5'd1 : write_byte[4:0];
		new_ram_on   = (write_byte[3:0] == RAM_ENABLE_KEY);
		ram_off      = {ram_bank_q, bus_address[12:0]} & ram_off_mask(ram_size_code_q);
		ram_idx      = ram_off[RAM_AW-1:0];
		ram_access   = (region == REGION_CART_RAM) && ram_on_q && ram_present;
		ram_we       = accept && action && ram_access;
		ram_re       = accept && !action && ram_access;
		rom_bank_sel = bus_address[14] ? rom_bank_q : 7'd0;
	end

	// Apply configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_bank_count_q <= 8'd2;
			ram_size_code_q  <= RAM_SIZE_NONE;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_ROM_BANK_COUNT) begin
				rom_bank_count_q <= cfg_data;
			end else if (cfg_index == CFG_RAM_SIZE_CODE) begin
				ram_size_code_q <= cfg_data[1:0];
			end
		end
	end

	// Update bank registers on write transactions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_on_q    <= 1'b0;
			rom_bank_q  <= 7'd1;
			ram_bank_q  <= 2'd0;
			bank_mode_q <= 1'b0;
		end else if (accept && action) begin
			unique case (region)
				REGION_RAM_ENABLE: ram_on_q <= new_ram_on;
				REGION_ROM_BANK: begin
					rom_bank_q <= ({rom_bank_q[6:5], 5'd0} | {2'd0, low_bits}) & bank_mask;
				end
				REGION_UPPER_BITS: begin
					if (!bank_mode_q) begin
						rom_bank_q <= {write_byte[1:0], rom_bank_q[4:0]} & bank_mask;
					end else begin
						ram_bank_q <= write_byte[1:0];
					end
				end
				REGION_MODE: bank_mode_q <= write_byte[0];
				default: ;
			endcase
		end
	end

	// Cartridge RAM: write at accept, registered read held while stalled
	always_ff @(posedge clk) begin
		if (ram_we) begin
			cart_ram[ram_idx] <= write_byte;
		end
		if (ram_re) begin
			ram_rd_data_q <= cart_ram[ram_idx];
		end
	end

	// Result stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Result stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			sel_ram_s1     <= ram_re;
			rom_hit_s1     <= !action && !bus_address[15];
			rom_address_s1 <= (!action && !bus_address[15]) ?
				{rom_bank_sel, bus_address[13:0]} : 21'd0;
			save_s1        <= action && (region == REGION_RAM_ENABLE) && ram_on_q &&
				!new_ram_on && ram_present;
		end
	end

	// Drive the result channel
	assign out_valid    = valid_s1;
	assign read_byte    = sel_ram_s1 ? ram_rd_data_q : 8'd0;
	assign rom_hit      = rom_hit_s1;
	assign rom_address  = rom_address_s1;
	assign save_request = save_s1;

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the MBC1 bank controller core with a predicting scoreboard.
`timescale 1ns / 100ps

module tb;
	import mbc1_pkg::*;

	localparam logic ACT_READ  = 1'b0;
	localparam logic ACT_WRITE = 1'b1;
	localparam int   PHASES    = 7;
	localparam int   PHASE_LEN = 185;

	localparam logic [7:0] PHASE_BANKS [PHASES] = '{8'd2, 8'd64, 8'd128, 8'd0, 8'd255, 8'd100,
		8'd32};
	localparam logic [1:0] PHASE_RAM [PHASES] = '{RAM_SIZE_NONE, RAM_SIZE_2K, RAM_SIZE_8K,
		RAM_SIZE_32K, RAM_SIZE_32K, RAM_SIZE_8K, RAM_SIZE_2K};

	typedef struct packed {
		logic [7:0]  rd_byte;
		logic        hit;
		logic [20:0] rom_addr;
		logic        save;
	} access_result_t;

	// Mirror of the bank registers and cartridge RAM; holds results still owed by the block
	class mapper_scoreboard;
		logic [7:0]     bank_count;
		logic [1:0]     ram_code;
		logic           ram_enabled;
		logic [6:0]     rom_bank;
		logic [1:0]     ram_bank;
		logic           mode_sel;
		logic [7:0]     ram_image [RAM_BYTES_DEF];
		bit             ram_valid [RAM_BYTES_DEF];
		access_result_t expected_results [$];
		int             errors;

		function new();
			bank_count  = 8'd2;
			ram_code    = RAM_SIZE_NONE;
			ram_enabled = 1'b0;
			rom_bank    = 7'd1;
			ram_bank    = 2'd0;
			mode_sel    = 1'b0;
			errors      = 0;
		endfunction

		function void set_register(logic [1:0] idx, logic [7:0] val);
			if (idx == CFG_ROM_BANK_COUNT)
				bank_count = val;
			else if (idx == CFG_RAM_SIZE_CODE)
				ram_code = val[1:0];
		endfunction

		function int ram_bytes();
			case (ram_code)
				RAM_SIZE_2K:  return 2048;
				RAM_SIZE_8K:  return 8192;
				RAM_SIZE_32K: return 32768;
				default:      return 0;
			endcase
		endfunction

		function bit ram_live();
			return ram_enabled && (ram_code != RAM_SIZE_NONE);
		endfunction

		// Physical RAM byte for an A000-BFFF address under the current bank and size
		function int ram_slot(logic [15:0] a);
			return int'({ram_bank, a[12:0]}) & (ram_bytes() - 1) & (RAM_BYTES_DEF - 1);
		endfunction

		function logic [6:0] bank_mask();
			logic [7:0] m;
			m = bank_count - 8'd1;
			return m[6:0] & 7'(MAX_ROM_BANKS_DEF - 1);
		endfunction

		// Apply one bus access to the mirrored state and work out its result
		function access_result_t predict_access(logic act, logic [15:0] a, logic [7:0] d);
			access_result_t r;
			logic           was_on;
			logic [4:0]     low;
			r = '0;
			if (act == ACT_WRITE) begin
				case (a[15:13])
					REGION_RAM_ENABLE: begin
						was_on      = ram_enabled;
						ram_enabled = (d[3:0] == RAM_ENABLE_KEY);
						r.save      = was_on && !ram_enabled && (ram_code != RAM_SIZE_NONE);
					end
					REGION_ROM_BANK: begin
						low = d[4:0];
						if (low == 5'd0)
							low = 5'd1;
						rom_bank = ({rom_bank[6:5], 5'd0} | {2'd0, low}) & bank_mask();
					end
					REGION_UPPER_BITS: begin
						if (!mode_sel)
							rom_bank = {d[1:0], rom_bank[4:0]} & bank_mask();
						else
							ram_bank = d[1:0];
					end
					REGION_MODE: begin
						mode_sel = d[0];
					end
					REGION_CART_RAM: begin
						if (ram_live()) begin
							ram_image[ram_slot(a)] = d;
							ram_valid[ram_slot(a)] = 1'b1;
						end
					end
					default: ;
				endcase
			end else if (a < 16'h4000) begin
				r.hit      = 1'b1;
				r.rom_addr = {5'd0, a};
			end else if (a < 16'h8000) begin
				r.hit      = 1'b1;
				r.rom_addr = {rom_bank, a[13:0]};
			end else if (a[15:13] == REGION_CART_RAM && ram_live()) begin
				r.rd_byte = ram_image[ram_slot(a)];
			end
			return r;
		endfunction

		function void take_access(logic act, logic [15:0] a, logic [7:0] d);
			expected_results.push_back(predict_access(act, a, d));
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		function void report(string field, logic [31:0] exp_val, logic [31:0] act_val);
			errors++;
			if (errors <= 10)
				$display("ERROR: %s expected %0h got %0h", field, exp_val, act_val);
		endfunction

		// Compare one accepted result with the oldest outstanding prediction
		function void match_result(logic [7:0] rd, logic hit, logic [20:0] ra, logic sv);
			access_result_t e;
			if (expected_results.size() == 0) begin
				report("result with no access outstanding, rom_address", 32'd0, 32'(ra));
				return;
			end
			e = expected_results.pop_front();
			if (rd !== e.rd_byte)
				report("read_byte", 32'(e.rd_byte), 32'(rd));
			if (hit !== e.hit)
				report("rom_hit", 32'(e.hit), 32'(hit));
			if (ra !== e.rom_addr)
				report("rom_address", 32'(e.rom_addr), 32'(ra));
			if (sv !== e.save)
				report("save_request", 32'(e.save), 32'(sv));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic        action;
	logic [15:0] bus_address;
	logic [7:0]  write_byte;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  read_byte;
	logic        rom_hit;
	logic [20:0] rom_address;
	logic        save_request;

	mapper_scoreboard sb = new();
	bit               in_steady;
	bit               out_steady;

	mbc1_bank_controller_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.bus_address  (bus_address),
		.write_byte   (write_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.read_byte    (read_byte),
		.rom_hit      (rom_hit),
		.rom_address  (rom_address),
		.save_request (save_request)
	);

	// Free-running 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Write one configuration register; the block must be idle
	task automatic write_register(logic [1:0] idx, logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_register(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Offer one bus access, hold it until taken, then draw the gap before the next
	task automatic send_access(logic act, logic [15:0] a, logic [7:0] d);
		int gap;
		in_valid    <= 1'b1;
		action      <= act;
		bus_address <= a;
		write_byte  <= d;
		do @(posedge clk); while (!in_ready);
		sb.take_access(act, a, d);
		if ($urandom_range(0, 39) == 0)
			in_steady = !in_steady;
		gap = in_steady ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid, wait for every owed result, then let the pipeline settle
	task automatic drain_bus();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Draw one access, weighted toward register programming and RAM traffic
	task automatic make_access(output logic act, output logic [15:0] a, output logic [7:0] d);
		int          kind;
		logic [12:0] off;
		kind = $urandom_range(0, 99);
		d    = 8'($urandom);
		act  = ACT_WRITE;
		if (kind < 35) begin
			// mostly a small pool of offsets so that reads find written bytes
			if ($urandom_range(0, 3) == 0)
				off = 13'($urandom);
			else
				off = {1'($urandom_range(0, 1)), 7'd0, 5'($urandom)};
			a   = {REGION_CART_RAM, off};
			act = 1'($urandom_range(0, 1));
			if (act == ACT_READ && sb.ram_live() && !sb.ram_valid[sb.ram_slot(a)])
				act = ACT_WRITE;
		end else if (kind < 45) begin
			a = {REGION_RAM_ENABLE, 13'($urandom)};
			if ($urandom_range(0, 2) != 0)
				d = {4'($urandom), RAM_ENABLE_KEY};
		end else if (kind < 55) begin
			a = {REGION_ROM_BANK, 13'($urandom)};
		end else if (kind < 63) begin
			a = {REGION_UPPER_BITS, 13'($urandom)};
		end else if (kind < 68) begin
			a = {REGION_MODE, 13'($urandom)};
		end else if (kind < 93) begin
			a   = {1'b0, 15'($urandom)};
			act = ACT_READ;
		end else begin
			if ($urandom_range(0, 1) == 0)
				a = 16'($urandom_range(16'h8000, 16'h9FFF));
			else
				a = 16'($urandom_range(16'hC000, 16'hFFFF));
			act = 1'($urandom_range(0, 1));
		end
	endtask

	// Result side: accept with random stalls and check each transaction
	initial begin
		int stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		out_ready <= 1'b1;
		forever begin
			do @(posedge clk); while (!(out_valid && out_ready));
			sb.match_result(read_byte, rom_hit, rom_address, save_request);
			if ($urandom_range(0, 39) == 0)
				out_steady = !out_steady;
			stall = out_steady ? 0 : $urandom_range(0, 4);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	// Stimulus: reset, directed accesses, then randomized phases under several settings
	initial begin
		logic        r_act;
		logic [15:0] r_addr;
		logic [7:0]  r_data;
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = CFG_ROM_BANK_COUNT;
		cfg_data    = 8'd0;
		in_valid    = 1'b0;
		action      = ACT_READ;
		bus_address = 16'd0;
		write_byte  = 8'd0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: ROM boundary addresses, RAM enable and disable, bank limits, modes, unmapped space
		write_register(CFG_ROM_BANK_COUNT, 8'd128);
		write_register(CFG_RAM_SIZE_CODE, {6'd0, RAM_SIZE_32K});
		send_access(ACT_READ,  16'h0000, 8'hFF);
		send_access(ACT_READ,  16'h3FFF, 8'h00);
		send_access(ACT_READ,  16'h4000, 8'h00);
		send_access(ACT_READ,  16'hA000, 8'h00);
		send_access(ACT_WRITE, 16'h0000, 8'h0A);
		send_access(ACT_WRITE, 16'hA000, 8'h5A);
		send_access(ACT_WRITE, 16'hBFFF, 8'hFF);
		send_access(ACT_READ,  16'hA000, 8'h00);
		send_access(ACT_READ,  16'hBFFF, 8'h00);
		send_access(ACT_WRITE, 16'h2000, 8'h00);
		send_access(ACT_WRITE, 16'h3FFF, 8'hFF);
		send_access(ACT_WRITE, 16'h4000, 8'h03);
		send_access(ACT_READ,  16'h7FFF, 8'h00);
		send_access(ACT_WRITE, 16'h6000, 8'h01);
		send_access(ACT_WRITE, 16'h5FFF, 8'h02);
		send_access(ACT_WRITE, 16'hB000, 8'h00);
		send_access(ACT_READ,  16'hB000, 8'hFF);
		send_access(ACT_WRITE, 16'h1FFF, 8'h00);
		send_access(ACT_WRITE, 16'h0000, 8'h00);
		send_access(ACT_READ,  16'h8000, 8'h00);
		send_access(ACT_WRITE, 16'h9FFF, 8'hFF);
		send_access(ACT_READ,  16'hFFFF, 8'h00);
		send_access(ACT_WRITE, 16'hC000, 8'hAA);
		send_access(ACT_WRITE, 16'h7FFF, 8'hFE);
		send_access(ACT_READ,  16'h4000, 8'h00);
		drain_bus();

		// random phases across bank counts and RAM sizes
		for (int p = 0; p < PHASES; p++) begin
			write_register(CFG_ROM_BANK_COUNT, PHASE_BANKS[p]);
			write_register(CFG_RAM_SIZE_CODE, {6'd0, PHASE_RAM[p]});
			for (int i = 0; i < PHASE_LEN; i++) begin
				make_access(r_act, r_addr, r_data);
				send_access(r_act, r_addr, r_data);
			end
			drain_bus();
		end

		if (sb.errors == 0 && sb.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Watchdog against a hung handshake
	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
